FILE: hdl/smeu_pkg.sv
package smeu_pkg;

    localparam int StackDepthDefault = 256;

    localparam logic [4:0] OP_HALT = 5'd0;
    localparam logic [4:0] OP_JUMP = 5'd1;
    localparam logic [4:0] OP_JNZ  = 5'd2;
    localparam logic [4:0] OP_DUP  = 5'd3;
    localparam logic [4:0] OP_SWAP = 5'd4;
    localparam logic [4:0] OP_DROP = 5'd5;
    localparam logic [4:0] OP_PSH4 = 5'd6;
    localparam logic [4:0] OP_PSH2 = 5'd7;
    localparam logic [4:0] OP_PSH1 = 5'd8;
    localparam logic [4:0] OP_ADD  = 5'd9;
    localparam logic [4:0] OP_SUB  = 5'd10;
    localparam logic [4:0] OP_MUL  = 5'd11;
    localparam logic [4:0] OP_DIV  = 5'd12;
    localparam logic [4:0] OP_MOD  = 5'd13;
    localparam logic [4:0] OP_EQ   = 5'd14;
    localparam logic [4:0] OP_NE   = 5'd15;
    localparam logic [4:0] OP_LT   = 5'd16;
    localparam logic [4:0] OP_GT   = 5'd17;
    localparam logic [4:0] OP_LE   = 5'd18;
    localparam logic [4:0] OP_GE   = 5'd19;
    localparam logic [4:0] OP_NOT  = 5'd20;
    localparam logic [4:0] OP_AND  = 5'd21;
    localparam logic [4:0] OP_OR   = 5'd22;

    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_STOP   = 3'd1;
    localparam logic [2:0] ST_UNDER  = 3'd2;
    localparam logic [2:0] ST_OVER   = 3'd3;
    localparam logic [2:0] ST_INDEX  = 3'd4;
    localparam logic [2:0] ST_DIVZ   = 3'd5;
    localparam logic [2:0] ST_OPCODE = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item, issue reads
        logic exec;      // compute with read data
        logic div_start;
        logic commit;    // write stack, update depth/stop, load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_sts;

endpackage

FILE: hdl/smeu_div.sv
module smeu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic [31:0] r_quo, r_rem, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_sh, w_sub;

    assign w_sh  = {r_rem, r_quo[31]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_sub[32]) begin
                r_rem <= w_sub[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

FILE: hdl/smeu_ctrl.sv
module smeu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_fire,
    input  logic          i_out_busy,
    input  smeu_pkg::t_sts i_sts,
    output smeu_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import smeu_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DONE} t_state;
    t_state r_state;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = i_in_fire;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_cmd.div_start = (r_state == S_EXEC) && i_sts.need_div;
    assign o_cmd.commit = (r_state == S_DONE) && !i_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_fire) r_state <= S_EXEC;
                S_EXEC: r_state <= i_sts.need_div ? S_DIV : S_DONE;
                S_DIV:  if (i_sts.div_done) r_state <= S_DONE;
                S_DONE: if (!i_out_busy) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |=> !o_in_ready) else $error("accepted while busy");
    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !o_cmd.commit) else $error("double commit");
    a_div_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_DIV) else $error("div sequencing");
endmodule

FILE: hdl/smeu_dpath.sv
module smeu_dpath #(
    parameter int STACK_DEPTH = smeu_pkg::StackDepthDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  smeu_pkg::t_cmd i_cmd,
    output smeu_pkg::t_sts o_sts,
    input  logic [15:0]    i_prog_len,
    input  logic [4:0]     i_func,
    input  logic [31:0]    i_operand,
    input  logic [15:0]    i_instr_addr,
    input  logic [31:0]    i_read_value,
    input  logic           i_is_input_op,
    input  logic           i_is_output_op,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [15:0]    o_next_addr,
    output logic           o_char_valid,
    output logic [7:0]     o_out_char,
    output logic [2:0]     o_status
);
    import smeu_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DFULL = DW'(STACK_DEPTH);

    logic [31:0] r_mem [STACK_DEPTH];
    logic [31:0] r_rd_a, r_rd_b;      // a: top-1 (or indexed), b: top
    logic [DW-1:0] r_depth;
    logic [2:0]  r_stop;
    logic [4:0]  r_func;
    logic [31:0] r_imm, r_rdv;
    logic [15:0] r_addr;
    logic        r_in, r_out;
    logic [AW-1:0] r_idx_addr;
    logic        r_idx_ok;
    logic        r_valid;

    // exec results
    logic [2:0]  r_st;
    logic [16:0] r_next;
    logic [31:0] r_wval, r_wval2;
    logic [AW-1:0] r_waddr, r_waddr2;
    logic        r_we, r_we2;
    logic [DW-1:0] r_ndepth;
    logic        r_chv;
    logic [7:0]  r_ch;
    logic        r_isdiv, r_ismod, r_na, r_nq;

    // load: read addresses
    logic [DW-1:0] w_ld_d;
    logic [32:0]   w_idx;
    logic [DW:0]   w_ia;
    assign w_ld_d = r_depth;
    assign w_idx  = {1'b0, i_operand};
    assign w_ia   = {1'b0, w_ld_d} - (DW+1)'(1) - (DW+1)'(i_operand[DW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_imm  <= i_operand;
            r_addr <= i_instr_addr;
            r_rdv  <= i_read_value;
            r_in   <= i_is_input_op;
            r_out  <= i_is_output_op;
            r_idx_ok <= w_idx < {{(33-DW){1'b0}}, w_ld_d};
            r_idx_addr <= w_ia[AW-1:0];
            if (i_func == OP_DUP || i_func == OP_SWAP)
                r_rd_a <= r_mem[w_ia[AW-1:0]];
            else
                r_rd_a <= r_mem[AW'(w_ld_d - DW'(2))];
            r_rd_b <= r_mem[AW'(w_ld_d - DW'(1))];
        end
    end

    // exec combinational
    logic [31:0] w_a, w_b, w_r, w_ua, w_ub;
    logic [2:0]  w_st;
    logic [16:0] w_nx;
    logic        w_we, w_we2, w_chv, w_slt, w_sgt;
    logic [DW-1:0] w_nd;
    logic [AW-1:0] w_wa, w_wa2;
    logic [31:0] w_wv, w_wv2;
    logic [63:0] w_prod;
    logic [16:0] w_a17;

    assign w_a = r_rd_a;
    assign w_b = r_rd_b;
    assign w_slt = (w_a ^ 32'h8000_0000) < (w_b ^ 32'h8000_0000);
    assign w_sgt = (w_b ^ 32'h8000_0000) < (w_a ^ 32'h8000_0000);
    assign w_prod = w_a * w_b;
    assign w_ua = w_a[31] ? 32'd0 - w_a : w_a;
    assign w_ub = w_b[31] ? 32'd0 - w_b : w_b;
    assign w_a17 = {1'b0, r_addr};
    assign o_sts.need_div = i_cmd.exec && r_stop == ST_RUN && r_addr < i_prog_len
        && !r_in && !r_out && (r_func == OP_DIV || r_func == OP_MOD)
        && r_depth >= DW'(2) && w_b != 32'd0;

    always_comb begin
        w_st = ST_RUN; w_nx = w_a17; w_we = 1'b0; w_we2 = 1'b0; w_chv = 1'b0;
        w_nd = r_depth; w_wa = AW'(r_depth); w_wa2 = AW'(r_depth - DW'(1));
        w_wv = r_rdv; w_wv2 = w_a; w_r = '0;
        unique case (r_func)
            OP_ADD: w_r = w_a + w_b;
            OP_SUB: w_r = w_a - w_b;
            OP_MUL: w_r = w_prod[31:0];
            OP_EQ:  w_r = {31'd0, w_a == w_b};
            OP_NE:  w_r = {31'd0, w_a != w_b};
            OP_LT:  w_r = {31'd0, w_slt};
            OP_GT:  w_r = {31'd0, w_sgt};
            OP_LE:  w_r = {31'd0, !w_sgt};
            OP_GE:  w_r = {31'd0, !w_slt};
            OP_AND: w_r = {31'd0, w_a != 0 && w_b != 0};
            OP_OR:  w_r = {31'd0, w_a != 0 || w_b != 0};
            default: w_r = '0;
        endcase
        if (r_in) begin
            if (r_depth >= DFULL) w_st = ST_OVER;
            else begin w_we = 1'b1; w_nd = r_depth + DW'(1); w_nx = w_a17 + 17'd1; end
        end else if (r_out) begin
            if (r_depth == '0) w_st = ST_UNDER;
            else begin w_chv = 1'b1; w_nd = r_depth - DW'(1); w_nx = w_a17 + 17'd1; end
        end else begin
            unique case (r_func)
                OP_HALT: w_st = ST_STOP;
                OP_JUMP: w_nx = {1'b0, r_imm[15:0]};
                OP_JNZ: begin
                    if (r_depth == '0) w_st = ST_UNDER;
                    else begin
                        w_nd = r_depth - DW'(1);
                        w_nx = (w_b != 0) ? {1'b0, r_imm[15:0]} : w_a17 + 17'd3;
                    end
                end
                OP_DUP: begin
                    if (!r_idx_ok) w_st = ST_INDEX;
                    else if (r_depth >= DFULL) w_st = ST_OVER;
                    else begin
                        w_we = 1'b1; w_wv = w_a; w_nd = r_depth + DW'(1);
                        w_nx = w_a17 + 17'd2;
                    end
                end
                OP_SWAP: begin
                    if (!r_idx_ok) w_st = ST_INDEX;
                    else begin
                        w_we = 1'b1; w_wa = r_idx_addr; w_wv = w_b;
                        w_we2 = 1'b1; w_wa2 = AW'(r_depth - DW'(1)); w_wv2 = w_a;
                        w_nx = w_a17 + 17'd2;
                    end
                end
                OP_DROP: begin
                    if (r_depth == '0) w_st = ST_UNDER;
                    else begin w_nd = r_depth - DW'(1); w_nx = w_a17 + 17'd1; end
                end
                OP_PSH4, OP_PSH2, OP_PSH1: begin
                    if (r_depth >= DFULL) w_st = ST_OVER;
                    else begin
                        w_we = 1'b1; w_nd = r_depth + DW'(1);
                        if (r_func == OP_PSH4) begin
                            w_wv = r_imm; w_nx = w_a17 + 17'd5;
                        end else if (r_func == OP_PSH2) begin
                            w_wv = {16'd0, r_imm[15:0]}; w_nx = w_a17 + 17'd3;
                        end else begin
                            w_wv = {24'd0, r_imm[7:0]}; w_nx = w_a17 + 17'd2;
                        end
                    end
                end
                OP_NOT: begin
                    if (r_depth == '0) w_st = ST_UNDER;
                    else begin
                        w_we = 1'b1; w_wa = AW'(r_depth - DW'(1));
                        w_wv = {31'd0, w_b == 0}; w_nx = w_a17 + 17'd1;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_LT,
                OP_GT, OP_LE, OP_GE, OP_AND, OP_OR: begin
                    if (r_depth < DW'(2)) w_st = ST_UNDER;
                    else if ((r_func == OP_DIV || r_func == OP_MOD) && w_b == 0)
                        w_st = ST_DIVZ;
                    else begin
                        w_we = 1'b1; w_wa = AW'(r_depth - DW'(2)); w_wv = w_r;
                        w_nd = r_depth - DW'(1); w_nx = w_a17 + 17'd1;
                    end
                end
                default: w_st = ST_OPCODE;
            endcase
        end
        if (r_stop != ST_RUN) w_st = r_stop;
        else if (r_addr >= i_prog_len) w_st = ST_STOP;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_st <= w_st; r_next <= w_nx;
            r_we <= w_we && w_st == ST_RUN; r_we2 <= w_we2 && w_st == ST_RUN;
            r_waddr <= w_wa; r_waddr2 <= w_wa2; r_wval <= w_wv; r_wval2 <= w_wv2;
            r_ndepth <= (w_st == ST_RUN) ? w_nd : r_depth;
            r_chv <= w_chv && w_st == ST_RUN; r_ch <= w_b[7:0];
            r_isdiv <= r_func == OP_DIV; r_ismod <= r_func == OP_MOD;
            r_na <= w_a[31]; r_nq <= w_a[31] ^ w_b[31];
        end
    end

    logic        w_ddone;
    logic [31:0] w_quo, w_rem, w_dres;
    smeu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(w_ua), .i_den(w_ub), .o_done(w_ddone), .o_quo(w_quo), .o_rem(w_rem)
    );
    assign o_sts.div_done = w_ddone;
    assign w_dres = r_ismod ? (r_na ? 32'd0 - w_rem : w_rem)
                            : (r_nq ? 32'd0 - w_quo : w_quo);

    logic w_run_ok;
    assign w_run_ok = (r_st == ST_RUN);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_we) r_mem[r_waddr] <= (r_isdiv || r_ismod) ? w_dres : r_wval;
            if (r_we2) r_mem[r_waddr2] <= r_wval2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_stop  <= ST_RUN;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_out_ready) r_valid <= 1'b0;
            if (i_cmd.commit) begin
                r_valid <= 1'b1;
                r_depth <= r_ndepth;
                if (r_stop == ST_RUN) begin
                    if (!w_run_ok) r_stop <= r_st;
                    else if (r_next >= {1'b0, i_prog_len}) r_stop <= ST_STOP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_char_valid <= r_chv;
            o_out_char   <= r_chv ? r_ch : 8'd0;
            if (r_stop != ST_RUN || !w_run_ok) begin
                o_next_addr <= r_addr;
                o_status    <= r_st;
            end else begin
                o_next_addr <= r_next[15:0];
                o_status    <= (r_next >= {1'b0, i_prog_len}) ? ST_STOP : ST_RUN;
            end
        end
    end

    assign o_out_valid = r_valid;

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_stop) != ST_RUN |-> r_stop == $past(r_stop)) else $error("stop lost");
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DFULL) else $error("depth overrun");
    a_err_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && !w_run_ok |-> !r_we && !r_we2) else $error("write on error");
endmodule

FILE: hdl/stack_machine_execute_unit.sv
// Stack machine execute unit.
// Input stream: one decoded instruction per transaction (s_axis_*). Output
// stream: one result per instruction (m_axis_*). Config stream (i_cfg_*):
// program_length, to be written only while idle (the block does not enforce it).
// Timing: an instruction is taken in the idle state, stack words are read on
// acceptance, the operation is evaluated the next cycle, and the stack is
// written and the result registered in S_DONE once the output register is
// free; div and mod first pass through the bit-serial divider in S_DIV. The
// next item is accepted the cycle after the result is registered: one item
// at a time.
// A result waits in the output register; the next item may be taken and
// evaluated meanwhile, but it is only written back once that register is
// free or being drained in the same cycle.
// Reset clears stack depth, the stop code and program_length; the stack
// memory is not cleared. A stalled receiver holds the result; one more item
// can be taken and evaluated, then input is blocked until the result is taken.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = smeu_pkg::StackDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // func, operand, instr_addr, read_value, 0 pad
    input  logic [1:0]  s_axis_tuser,  // is_input_op, is_output_op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // next_addr, char_valid, out_char, status, 0 pad
);
    import smeu_pkg::*;

    logic [15:0] r_prog_len;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_rdy, w_fire, w_out_busy;
    logic [15:0] w_na;
    logic w_chv;
    logic [7:0] w_ch;
    logic [2:0] w_st;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_prog_len <= '0;
        else if (i_cfg_valid) r_prog_len <= i_cfg_data;
    end

    assign w_out_busy = m_axis_tvalid && !m_axis_tready;
    assign s_axis_tready = w_rdy;
    assign w_fire = s_axis_tvalid && w_rdy;

    smeu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_out_busy(w_out_busy), .i_sts(w_sts), .o_cmd(w_cmd), .o_in_ready(w_rdy)
    );

    smeu_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_prog_len(r_prog_len),
        .i_func(s_axis_tdata[4:0]), .i_operand(s_axis_tdata[36:5]),
        .i_instr_addr(s_axis_tdata[52:37]), .i_read_value(s_axis_tdata[84:53]),
        .i_is_input_op(s_axis_tuser[0]), .i_is_output_op(s_axis_tuser[1]),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_next_addr(w_na), .o_char_valid(w_chv), .o_out_char(w_ch), .o_status(w_st)
    );

    assign m_axis_tdata = {4'd0, w_st, w_ch, w_chv, w_na};
endmodule
